@@ design/bust_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bust_pkg
// Shared types and constants for the bounded unique set table: field widths,
// word layout, opcodes and controller states.
// ----------------------------------------------------------------------------
package bust_pkg;

  // Default geometry
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Field widths on the ports
  localparam int OP_W     = 2;
  localparam int KEY_IN_W = 32;
  localparam int RANK_W   = 6;
  localparam int OK_W     = 1;
  localparam int FILL_W   = 7;
  localparam int CAP_W    = 7;

  // Word widths (packed fields, rounded up to whole bytes)
  localparam int IN_BITS     = OP_W + KEY_IN_W + RANK_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = OK_W + KEY_IN_W + FILL_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Field positions in the input word
  localparam int IN_OP_LSB   = 0;
  localparam int IN_KEY_LSB  = IN_OP_LSB + OP_W;
  localparam int IN_RANK_LSB = IN_KEY_LSB + KEY_IN_W;

  // Field positions in the output word
  localparam int OUT_OK_LSB   = 0;
  localparam int OUT_KEY_LSB  = OUT_OK_LSB + OK_W;
  localparam int OUT_FILL_LSB = OUT_KEY_LSB + KEY_IN_W;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_RANK     = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CAND_RD,
    ST_CAND_LD,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESP
  } state_t;

endpackage : bust_pkg
`default_nettype wire

@@ design/bounded_unique_set_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_unique_set_table_top
// Set of distinct keys in a table memory with one write and one read port and a fill count.
// Insert, erase, contains and rank query, one request in flight at a time.
// ----------------------------------------------------------------------------
// Sequence, N = keys held: insert, contains and erase scan the entries until a
// match or the end; an erase hit then moves the last entry into the hole. A full
// insert or a rank at or above N goes straight to the result. A rank query fetches
// a candidate, then scans all N entries for smaller keys, up to N candidates.
// Throughput: one request at a time, set by the one-entry-per-cycle memory
// read port; the next word is taken once the result is in the output register.
// Reset: fill count cleared, capacity set to 64; table contents are not cleared.
module bounded_unique_set_table_top #(
  parameter int DEPTH     = bust_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = bust_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel; tdata: opcode[1:0], key[33:2], rank[39:34]
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [bust_pkg::IN_DATA_W-1:0]  in_tdata,
  // result channel; tdata: ok[0], found_key[32:1], fill_count[39:33]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [bust_pkg::OUT_DATA_W-1:0]      out_tdata,
  // capacity write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bust_pkg::CAP_W-1:0]      cfg_data
);

  import bust_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW   = (CW > RANK_W) ? CW : RANK_W;
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // Table memory
  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] rd_data_r;

  // Control and request registers
  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;

  // Scan registers
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [AW-1:0]        cand_idx_r, cand_idx_nxt;
  logic [KEY_WIDTH-1:0] cand_r, cand_nxt;
  logic [CW-1:0]        less_r, less_nxt;

  // Pending result and output register
  logic                 res_ok_r, res_ok_nxt;
  logic [KEY_WIDTH-1:0] res_key_r, res_key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [KEY_IN_W-1:0]  out_key_r, out_key_nxt;
  logic [FILL_W-1:0]    out_fill_r, out_fill_nxt;

  // Request fields
  op_t                  in_op;
  logic [KEY_IN_W-1:0]  in_key;
  logic [RANK_W-1:0]    in_rank;
  logic [KEY_WIDTH-1:0] in_key_m;

  // Derived conditions
  logic                 in_acc;
  logic                 full;
  logic                 rank_oor;
  logic                 issue;
  logic                 scan_end;
  logic                 rd_match;
  logic                 rd_less;
  logic [CW-1:0]        less_tot;
  logic                 rank_hit;
  logic                 out_free;
  logic [CW-1:0]        last_idx;

  assign in_op    = op_t'(in_tdata[IN_KEY_LSB-1:IN_OP_LSB]);
  assign in_key   = in_tdata[IN_RANK_LSB-1:IN_KEY_LSB];
  assign in_rank  = in_tdata[IN_BITS-1:IN_RANK_LSB];
  assign in_key_m = KEY_WIDTH'(in_key);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign full     = (CMPW'(count_r) >= CMPW'(cap_r)) || (count_r == CW'(DEPTH));
  assign rank_oor = (RW'(in_rank) >= RW'(count_r));
  assign issue    = (idx_r < count_r);
  assign scan_end = !issue;
  assign rd_match = rd_vld_r && (rd_data_r == key_r);
  assign rd_less  = rd_vld_r && (rd_data_r < cand_r);
  assign less_tot = less_r + CW'(rd_less);
  assign rank_hit = (RW'(less_tot) == RW'(rank_r));
  assign out_free = !out_valid_r || out_tready;
  assign last_idx = count_r - CW'(1);

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_INSERT && full) begin
            state_nxt = ST_RESP;
          end else if (in_op == OP_RANK) begin
            state_nxt = rank_oor ? ST_RESP : ST_CAND_RD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (op_r == OP_RANK) begin
          if (scan_end) begin
            state_nxt = rank_hit ? ST_RESP : ST_CAND_RD;
          end
        end else if (rd_match) begin
          state_nxt = (op_r == OP_ERASE) ? ST_MOVE_RD : ST_RESP;
        end else if (scan_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_CAND_RD: state_nxt = ST_CAND_LD;
      ST_CAND_LD: state_nxt = ST_SCAN;
      ST_MOVE_RD: state_nxt = ST_MOVE_WR;
      ST_MOVE_WR: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    rank_nxt      = rank_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    slot_nxt      = slot_r;
    cand_idx_nxt  = cand_idx_r;
    cand_nxt      = cand_r;
    less_nxt      = less_r;
    res_ok_nxt    = res_ok_r;
    res_key_nxt   = res_key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_fill_nxt  = out_fill_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = key_r;
    mem_raddr     = idx_r[AW-1:0];

    if (cfg_valid) begin
      cap_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_op;
          key_nxt      = in_key_m;
          rank_nxt     = in_rank;
          idx_nxt      = '0;
          rd_vld_nxt   = 1'b0;
          cand_idx_nxt = '0;
          less_nxt     = '0;
          res_ok_nxt   = 1'b0;
          res_key_nxt  = '0;
        end
      end
      ST_SCAN: begin
        // stream entries 0..count-1, one read issued per cycle
        if (issue) begin
          mem_raddr  = idx_r[AW-1:0];
          idx_nxt    = idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[AW-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (op_r == OP_RANK) begin
          less_nxt = less_tot;
          if (scan_end) begin
            if (rank_hit) begin
              res_ok_nxt  = 1'b1;
              res_key_nxt = cand_r;
            end else begin
              cand_idx_nxt = cand_idx_r + AW'(1);
            end
          end
        end else if (rd_match) begin
          slot_nxt = rd_idx_r;
          if (op_r == OP_CONTAINS) begin
            res_ok_nxt = 1'b1;
          end
        end else if (scan_end && op_r == OP_INSERT) begin
          // absent and room left: append
          mem_we     = 1'b1;
          mem_waddr  = count_r[AW-1:0];
          mem_wdata  = key_r;
          count_nxt  = count_r + CW'(1);
          res_ok_nxt = 1'b1;
        end
      end
      ST_CAND_RD: begin
        mem_raddr = cand_idx_r;
      end
      ST_CAND_LD: begin
        cand_nxt   = rd_data_r;
        idx_nxt    = '0;
        rd_vld_nxt = 1'b0;
        less_nxt   = '0;
      end
      ST_MOVE_RD: begin
        mem_raddr = last_idx[AW-1:0];
      end
      ST_MOVE_WR: begin
        // last entry fills the hole left by the erased key
        mem_we     = 1'b1;
        mem_waddr  = slot_r;
        mem_wdata  = rd_data_r;
        count_nxt  = last_idx;
        res_ok_nxt = 1'b1;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_key_nxt   = KEY_IN_W'(res_key_r);
          out_fill_nxt  = FILL_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    rank_r     <= rank_nxt;
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    slot_r     <= slot_nxt;
    cand_idx_r <= cand_idx_nxt;
    cand_r     <= cand_nxt;
    less_r     <= less_nxt;
    res_ok_r   <= res_ok_nxt;
    res_key_r  <= res_key_nxt;
    out_ok_r   <= out_ok_nxt;
    out_key_r  <= out_key_nxt;
    out_fill_r <= out_fill_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_fill_r, out_key_r, out_ok_r});

endmodule : bounded_unique_set_table_top
`default_nettype wire

@@ design/bust_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bust_checker
// Port-level checks on the set table: result word stability, busy after a
// request, reset of the result channel, and consistency of result fields.
// ----------------------------------------------------------------------------
module bust_checker #(
  parameter int DEPTH = bust_pkg::DEPTH_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [bust_pkg::OUT_DATA_W-1:0] out_tdata
);

  import bust_pkg::*;

  logic                ok_f;
  logic [KEY_IN_W-1:0] key_f;
  logic [FILL_W-1:0]   fill_f;

  assign ok_f   = out_tdata[OUT_OK_LSB];
  assign key_f  = out_tdata[OUT_FILL_LSB-1:OUT_KEY_LSB];
  assign fill_f = out_tdata[OUT_BITS-1:OUT_FILL_LSB];

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one request at a time: busy in the cycle after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while the previous one is in progress");

  // a failed request never reports a key
  a_fail_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ok_f |-> key_f == '0)
    else $error("failed request reports a key");

  // fill count within the table depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 127) || (int'(fill_f) <= DEPTH))
    else $error("fill count above table depth");

  // result channel empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule : bust_checker

bind bounded_unique_set_table_top bust_checker #(.DEPTH(DEPTH)) u_bust_checker (.*);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Bench for the bounded unique set table. A directed run covers the empty
// table, duplicate keys, erase from the front and the middle, and ranks at and
// beyond the fill count. Random phases then follow, each under its own
// capacity (zero, above the table depth, below the fill count). Every word
// accepted on the request side goes into a tracker. The tracker keeps its
// own copy of the key set and compares each result word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bust_pkg::*;

  localparam int STALL_LIMIT   = 20000;  // above the longest rank query at full depth
  localparam int PHASE_ITEMS   = 128;
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_CAP [NUM_PHASES] = '{8, 0, 16, 3, 127, 1, 64, 5, 12};

  typedef struct packed {
    logic [FILL_W-1:0]   fill_count;
    logic [KEY_IN_W-1:0] found_key;
    logic                ok;
  } table_result_t;

  // Tracks the key set and holds the results still owed by the block
  class key_set_tracker;
    logic [KEY_IN_W-1:0] held [DEPTH_DEF];
    int unsigned         held_count;
    int unsigned         capacity;
    table_result_t       expected_results [$];
    int unsigned         failures;

    function new();
      held_count = 0;
      capacity   = 32'(CAP_RESET);
      failures   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = 32'(value);
    endfunction

    // slot of a key, or held_count when absent
    function int unsigned slot_of(logic [KEY_IN_W-1:0] key);
      for (int unsigned i = 0; i < held_count; i++)
        if (held[i] == key) return i;
      return held_count;
    endfunction

    function void note_request(op_t op, logic [KEY_IN_W-1:0] key, logic [RANK_W-1:0] rank);
      int unsigned   limit;
      int unsigned   slot;
      int unsigned   smaller;
      table_result_t res;
      limit = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
      res   = '0;
      case (op)
        OP_INSERT: begin
          if (held_count < limit && slot_of(key) == held_count) begin
            held[held_count] = key;
            held_count++;
            res.ok = 1'b1;
          end
        end
        OP_ERASE: begin
          slot = slot_of(key);
          if (slot < held_count) begin
            // last entry fills the hole
            held[slot] = held[held_count-1];
            held_count--;
            res.ok = 1'b1;
          end
        end
        OP_CONTAINS: res.ok = (slot_of(key) < held_count);
        OP_RANK: begin
          // keys are distinct, so rank r has exactly r smaller keys
          if (rank < held_count) begin
            for (int unsigned i = 0; i < held_count; i++) begin
              smaller = 0;
              for (int unsigned j = 0; j < held_count; j++)
                if (held[j] < held[i]) smaller++;
              if (smaller == rank) begin
                res.found_key = held[i];
                res.ok        = 1'b1;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      res.fill_count = FILL_W'(held_count);
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      table_result_t want;
      table_result_t got;
      got.ok         = word[OUT_OK_LSB];
      got.found_key  = word[OUT_KEY_LSB +: KEY_IN_W];
      got.fill_count = word[OUT_FILL_LSB +: FILL_W];
      if (expected_results.size() == 0) begin
        $error("result word %h with no request outstanding", word);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        failures++;
      end
      if (got.found_key !== want.found_key) begin
        $error("found_key: expected %h, got %h", want.found_key, got.found_key);
        failures++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        failures++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data;

  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    quiet_cycles;
  key_set_tracker key_set = new();

  bounded_unique_set_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random back-pressure, check on every accepted word
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) key_set.check_result(out_tdata);
  end

  // Watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge; valid stays high on exit
  task automatic send_request(input op_t op, input logic [KEY_IN_W-1:0] key,
                              input logic [RANK_W-1:0] rank);
    logic [IN_DATA_W-1:0] word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    word = '0;
    word[IN_OP_LSB +: OP_W]       = op;
    word[IN_KEY_LSB +: KEY_IN_W]  = key;
    word[IN_RANK_LSB +: RANK_W]   = rank;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    key_set.note_request(op, key, rank);
    @(negedge clk);
  endtask

  // Hold off requests until every result is back, then let the block settle
  task automatic wait_for_results(input int settle);
    in_tvalid <= 1'b0;
    while (key_set.expected_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    key_set.set_capacity(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random requests: keys mostly held or from a small pool so hits are common
  task automatic run_phase(input int cap, input int items);
    logic [KEY_IN_W-1:0] pool_base;
    logic [KEY_IN_W-1:0] key;
    logic [RANK_W-1:0]   rank;
    int unsigned         pool_span;
    int unsigned         pick;
    int unsigned         w_ins;
    int unsigned         w_ers;
    op_t                 op;
    pool_base = $urandom;
    pool_span = (cap > DEPTH_DEF ? DEPTH_DEF : cap) * 2 + 4;
    // big tables: fewer rank queries, more inserts to fill up
    w_ins = (cap >= 16) ? 50 : 35;
    w_ers = (cap >= 16) ? 20 : 25;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(39) == 0) wait_for_results(2);
      pick = $urandom_range(99);
      if (pick < w_ins)              op = OP_INSERT;
      else if (pick < w_ins + w_ers) op = OP_ERASE;
      else if (pick < w_ins + w_ers + 20) op = OP_CONTAINS;
      else                           op = OP_RANK;
      pick = $urandom_range(99);
      if (pick < 60 && key_set.held_count > 0)
        key = key_set.held[$urandom_range(key_set.held_count - 1)];
      else if (pick < 85)
        key = pool_base + $urandom_range(pool_span - 1);
      else
        key = $urandom;
      if ($urandom_range(99) < 70 && key_set.held_count < 64)
        rank = RANK_W'($urandom_range(key_set.held_count));
      else
        rank = RANK_W'($urandom_range(63));
      send_request(op, key, rank);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 32;
    recv_idle_pct = 58;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes of key and rank, duplicates, erase paths
    send_request(OP_RANK,     32'h0000_0000, 6'd0);
    send_request(OP_CONTAINS, 32'h0000_0000, 6'd63);
    send_request(OP_ERASE,    32'h0000_0000, 6'd0);
    send_request(OP_INSERT,   32'hFFFF_FFFF, 6'd63);
    send_request(OP_INSERT,   32'h0000_0000, 6'd0);
    send_request(OP_INSERT,   32'hFFFF_FFFF, 6'd0);
    send_request(OP_INSERT,   32'h8000_0000, 6'd21);
    send_request(OP_INSERT,   32'h7FFF_FFFF, 6'd42);
    send_request(OP_INSERT,   32'h1234_5678, 6'd0);
    send_request(OP_CONTAINS, 32'h0000_0000, 6'd0);
    send_request(OP_CONTAINS, 32'h0000_0005, 6'd0);
    send_request(OP_RANK,     32'hFFFF_FFFF, 6'd0);
    send_request(OP_RANK,     32'h0000_0000, 6'd4);
    send_request(OP_RANK,     32'h0000_0000, 6'd2);
    send_request(OP_RANK,     32'h0000_0000, 6'd5);
    send_request(OP_RANK,     32'h0000_0000, 6'd63);
    send_request(OP_ERASE,    32'h0000_0000, 6'd63);
    send_request(OP_ERASE,    32'h0000_0000, 6'd0);
    send_request(OP_ERASE,    32'h1234_5678, 6'd0);
    send_request(OP_RANK,     32'h0000_0000, 6'd0);
    send_request(OP_ERASE,    32'hFFFF_FFFF, 6'd0);
    send_request(OP_CONTAINS, 32'hFFFF_FFFF, 6'd0);
    send_request(OP_RANK,     32'h0000_0000, 6'd1);
    wait_for_results(8);

    // Random phases, idling pattern changes every third phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 32;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(CAP_W'(PHASE_CAP[p]));
      run_phase(PHASE_CAP[p], PHASE_ITEMS);
      wait_for_results(8);
    end

    wait_for_results(16);
    if (key_set.failures == 0 && key_set.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bust_pkg.sv
design/bounded_unique_set_table_top.sv
design/bust_checker.sv
bench/testbench.sv
